>>> rtl/core/mctt_pkg.sv
// ----------------------------------------------------------------------------
// mctt_pkg
// Shared constants and types for the MIDI clock tempo tracker.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int OP_W      = 8;
  localparam int TS_W      = 32;
  localparam int THR_W     = 24;
  localparam int TICK_W    = 32;
  localparam int ENTRY_W   = 32;
  localparam int SUM_W     = 36;
  localparam int DUR_W     = 37;
  localparam int FRAC_W    = 8;
  localparam int KIND_W    = 2;

  localparam int WINDOW_LEN_DEF = 24;

  localparam logic [OP_W-1:0] OP_START = 8'hFA;
  localparam logic [OP_W-1:0] OP_CLOCK = 8'hF8;
  localparam logic [OP_W-1:0] OP_STOP  = 8'hFC;

  localparam logic [KIND_W-1:0] EV_START  = 2'd0;
  localparam logic [KIND_W-1:0] EV_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] EV_UPDATE = 2'd2;

  localparam logic [THR_W-1:0] THRESH_RESET = 24'd4000000;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

>>> rtl/core/midi_clock_tempo_tracker_core.sv
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker_core
// MIDI real-time byte tracker: beat timing, windowed tempo average, events.
// ----------------------------------------------------------------------------
// Events: an accepted start or stop goes to the emit state, which registers
// its beat on out_valid once the output is free; a tempo update runs delta,
// check, 32-step divider, update, emit. No new byte is taken until the
// sequencer is back in idle; the serial divider scales each beat by the fill
// count. A first or stalled clock skips the divider. Reset: synchronous, clears
// the sequencer, counters, sum and the window's per-entry valid bits; threshold returns to 4000000 us.
module midi_clock_tempo_tracker_core #(
  parameter int WINDOW_LEN = mctt_pkg::WINDOW_LEN_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [mctt_pkg::THR_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [mctt_pkg::OP_W-1:0]     op,
  input  logic [mctt_pkg::TS_W-1:0]     timestamp_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [mctt_pkg::KIND_W-1:0]   event_kind,
  output logic [mctt_pkg::TICK_W-1:0]   tick_count,
  output logic [mctt_pkg::SUM_W-1:0]    beat_period
);
  import mctt_pkg::*;

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam logic [POS_W-1:0]  POS_LAST = POS_W'(WINDOW_LEN - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WINDOW_LEN);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CHK  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_UPD  = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0]            state;
  logic [THR_W-1:0]      stall_threshold_us;
  logic [TICK_W-1:0]     tick_counter;
  logic                  last_time_valid;
  logic [TS_W-1:0]       last_time;
  logic [TS_W-1:0]       delta;
  logic [ENTRY_W-1:0]    window [WINDOW_LEN];
  logic [WINDOW_LEN-1:0] window_valid;
  logic [POS_W-1:0]      write_position;
  logic [FILL_W-1:0]     fill_count;
  logic [SUM_W-1:0]      running_sum;
  logic [KIND_W-1:0]     kind;

  logic                  accept;
  logic [DUR_W-1:0]      dur;
  logic [FILL_W-1:0]     fill_next;
  logic                  div_start;
  logic [ENTRY_W-1:0]    div_q;
  div_stat_t             div_stat;
  logic [ENTRY_W-1:0]    old_entry;
  logic                  emit_ok;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign emit_ok  = !out_valid || !out_stall;

  always_comb begin
    dur       = DUR_W'({delta, 4'b0}) + DUR_W'({delta, 3'b0});
    fill_next = (fill_count == FILL_MAX) ? fill_count : fill_count + 1'b1;
    div_start = (state == S_CHK) && (dur <= DUR_W'(stall_threshold_us));
  end

  mctt_div #(
    .DIVIDEND_W (ENTRY_W),
    .DIVISOR_W  (FILL_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend ({dur[THR_W-1:0], {FRAC_W{1'b0}}}),
    .divisor  (fill_next),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      stall_threshold_us <= THRESH_RESET;
    end else if (cfg_write) begin
      stall_threshold_us <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      tick_counter    <= '0;
      last_time_valid <= 1'b0;
      last_time       <= '0;
      window_valid    <= '0;
      write_position  <= '0;
      fill_count      <= '0;
      running_sum     <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            priority if (op == OP_START) begin
              tick_counter <= '1;
              kind         <= EV_START;
              state        <= S_EMIT;
            end else if (op == OP_STOP) begin
              kind  <= EV_STOP;
              state <= S_EMIT;
            end else if (op == OP_CLOCK) begin
              // every clock re-records its time; only a later one measures
              last_time_valid <= 1'b1;
              last_time       <= timestamp_us;
              delta           <= timestamp_us - last_time;
              if (last_time_valid) begin
                state <= S_CHK;
              end
            end else begin
              // drop any other byte
            end
          end
        end
        S_CHK: begin
          if (div_start) begin
            fill_count <= fill_next;
            old_entry  <= window_valid[write_position] ? window[write_position] : '0;
            state      <= S_DIV;
          end else begin
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            state <= S_UPD;
          end
        end
        S_UPD: begin
          running_sum <= running_sum + SUM_W'(div_q) - SUM_W'(old_entry);
          window[write_position]       <= div_q;
          window_valid[write_position] <= 1'b1;
          write_position <= (write_position == POS_LAST) ? '0 : write_position + 1'b1;
          tick_counter   <= tick_counter + 1'b1;
          kind           <= EV_UPDATE;
          state          <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit_ok) begin
            out_valid  <= 1'b1;
            event_kind <= kind;
            if (kind == EV_UPDATE) begin
              tick_count  <= tick_counter;
              beat_period <= running_sum;
            end else begin
              tick_count  <= '0;
              beat_period <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= FILL_MAX)
    else $error("fill count beyond window length");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    write_position <= POS_LAST)
    else $error("write position beyond window");

  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_stat.done) |=> (state == S_UPD))
    else $error("divider result not consumed");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE || state == S_EMIT) |-> !div_stat.busy)
    else $error("divider busy outside divide phase");

  a_emit_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EMIT))
    else $error("beat emitted outside emit state");

endmodule

>>> rtl/core/mctt_div.sv
// ----------------------------------------------------------------------------
// mctt_div
// Restoring serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mctt_div #(
  parameter int DIVIDEND_W = mctt_pkg::ENTRY_W,
  parameter int DIVISOR_W  = 5
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic [DIVIDEND_W-1:0] quotient,
  output mctt_pkg::div_stat_t   stat
);
  import mctt_pkg::*;

  localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DIVIDEND_W - 1);

  logic [DIVIDEND_W-1:0] acc;
  logic [DIVISOR_W-1:0]  rem;
  logic [DIVISOR_W-1:0]  dvs;
  logic [CNT_W-1:0]      cnt;
  logic                  busy;
  logic                  done;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    diff;
  logic                  fits;

  always_comb begin
    trial = {rem, acc[DIVIDEND_W-1]};
    diff  = trial - {1'b0, dvs};
    fits  = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (cnt == LAST)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc <= dividend;
      rem <= '0;
      dvs <= divisor;
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (fits) begin
        rem <= diff[DIVISOR_W-1:0];
        acc <= {acc[DIVIDEND_W-2:0], 1'b1};
      end else begin
        rem <= trial[DIVISOR_W-1:0];
        acc <= {acc[DIVIDEND_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = acc;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

>>> tb/midi_clock_tempo_tracker_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// midi_clock_tempo_tracker_core_tb
// Drives MIDI bytes with timestamps into the tempo tracker and checks
// every start, stop and tempo update against a cycle-free predictor of the
// window average. Runs through several stall thresholds and idling patterns.
// ----------------------------------------------------------------------------
module midi_clock_tempo_tracker_core_tb;
  import mctt_pkg::*;

  localparam int WIN            = WINDOW_LEN_DEF;
  localparam int QUIET_LIMIT    = 2000;
  localparam int SETTLE_CYCLES  = 64;
  localparam int PHASE_EVENTS   = 70;

  // bytes the tracker should pass over
  localparam logic [OP_W-1:0] OP_NOTE_OFF_LOW = 8'h00;
  localparam logic [OP_W-1:0] OP_DATA_TOP     = 8'h7F;
  localparam logic [OP_W-1:0] OP_TICK_UNDEF   = 8'hF9;
  localparam logic [OP_W-1:0] OP_CONTINUE     = 8'hFB;
  localparam logic [OP_W-1:0] OP_ACTIVE_SENSE = 8'hFE;
  localparam logic [OP_W-1:0] OP_SYS_RESET    = 8'hFF;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [TICK_W-1:0] ticks;
    logic [SUM_W-1:0]  period;
  } tempo_event_t;

  class tempo_scoreboard;
    bit [THR_W-1:0]   stall_limit_us;
    bit [TICK_W-1:0]  tick_counter;
    bit               have_last;
    bit [TS_W-1:0]    last_stamp;
    bit [ENTRY_W-1:0] window [WIN];
    int unsigned      wr_pos;
    int unsigned      fill;
    bit [SUM_W-1:0]   beat_sum;
    tempo_event_t     pending[$];
    int unsigned      errors;

    function new();
      stall_limit_us = THRESH_RESET;
      tick_counter   = '0;
      have_last      = 1'b0;
      last_stamp     = '0;
      foreach (window[i]) window[i] = '0;
      wr_pos         = 0;
      fill           = 0;
      beat_sum       = '0;
      errors         = 0;
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      errors++;
    endtask

    // Predict the event, if any, that one accepted byte causes.
    function void note_byte(logic [OP_W-1:0] b, logic [TS_W-1:0] ts);
      bit [TS_W-1:0]    delta;
      bit [DUR_W-1:0]   dur;
      bit [DUR_W+FRAC_W-1:0] scaled;
      bit [ENTRY_W-1:0] entry;
      if (b == OP_START) begin
        tick_counter = '1;
        pending.push_back('{EV_START, '0, '0});
      end else if (b == OP_STOP) begin
        pending.push_back('{EV_STOP, '0, '0});
      end else if (b == OP_CLOCK) begin
        if (!have_last) begin
          have_last  = 1'b1;
          last_stamp = ts;
        end else begin
          delta      = ts - last_stamp;
          dur        = DUR_W'(delta) * DUR_W'(24);
          last_stamp = ts;
          if (dur <= DUR_W'(stall_limit_us)) begin
            if (fill < WIN) fill++;
            scaled = {dur, {FRAC_W{1'b0}}} / (DUR_W+FRAC_W)'(fill);
            entry  = scaled[ENTRY_W-1:0];
            beat_sum = beat_sum + SUM_W'(entry) - SUM_W'(window[wr_pos]);
            window[wr_pos] = entry;
            wr_pos = (wr_pos + 1) % WIN;
            tick_counter++;
            pending.push_back('{EV_UPDATE, tick_counter, beat_sum});
          end
        end
      end
    endfunction

    task check_event(logic [KIND_W-1:0] kind, logic [TICK_W-1:0] ticks,
                     logic [SUM_W-1:0] period);
      tempo_event_t exp_ev;
      if (pending.size() == 0) begin
        report($sformatf("unexpected event kind %0d ticks %0d period %h",
                         kind, ticks, period));
      end else begin
        exp_ev = pending.pop_front();
        if (kind !== exp_ev.kind)
          report($sformatf("event_kind %0d, want %0d", kind, exp_ev.kind));
        if (ticks !== exp_ev.ticks)
          report($sformatf("tick_count %0d, want %0d", ticks, exp_ev.ticks));
        if (period !== exp_ev.period)
          report($sformatf("beat_period %h, want %h", period, exp_ev.period));
      end
    endtask
  endclass

  logic               clk;
  logic               rst          = 1'b1;
  logic               cfg_write    = 1'b0;
  logic [THR_W-1:0]   cfg_data     = '0;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [OP_W-1:0]    op           = '0;
  logic [TS_W-1:0]    timestamp_us = '0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic [KIND_W-1:0]  event_kind;
  logic [TICK_W-1:0]  tick_count;
  logic [SUM_W-1:0]   beat_period;

  tempo_scoreboard sb;
  int          idle_pct    = 0;
  int          stall_pct   = 0;
  int          quiet_count = 0;
  int          sent_events = 0;
  bit [TS_W-1:0] stamp;

  midi_clock_tempo_tracker_core #(.WINDOW_LEN(WIN)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .timestamp_us (timestamp_us),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .event_kind   (event_kind),
    .tick_count   (tick_count),
    .beat_period  (beat_period)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample handshakes at the edge; outputs still hold their pre-edge values.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_byte(op, timestamp_us);
      if (out_valid && !out_stall) sb.check_event(event_kind, tick_count, beat_period);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_count = 0;
      end else begin
        quiet_count++;
      end
      if (quiet_count >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task send_beat(input logic [OP_W-1:0] b, input logic [TS_W-1:0] ts);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= b;
    timestamp_us <= ts;
    do @(posedge clk); while (in_stall);
    if (b == OP_START || b == OP_STOP || b == OP_CLOCK) sent_events++;
  endtask

  // Drop valid, wait for every predicted event, then let a stray clock byte finish.
  task drain;
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_threshold(input logic [THR_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    sb.stall_limit_us = value;
  endtask

  function automatic bit [TS_W-1:0] next_delta();
    int unsigned most;
    int unsigned r;
    most = sb.stall_limit_us / 24;
    r    = $urandom_range(99);
    if (r < 70)      return $urandom_range(most, 0);
    else if (r < 78) return most;
    else if (r < 84) return '0;
    else if (r < 90) return most + 1;
    else if (r < 96) return $urandom_range(most * 4 + 100, most + 1);
    else             return $urandom;
  endfunction

  task run_directed;
    send_beat(OP_CLOCK, 32'd1000);             // first clock only records time
    send_beat(OP_CLOCK, 32'd1000);             // zero delta
    send_beat(OP_START, 32'd1000);
    send_beat(OP_CLOCK, 32'd167666);           // longest beat under the threshold
    send_beat(OP_CLOCK, 32'd334333);           // one microsecond over: stalled
    send_beat(OP_CLOCK, 32'd355166);
    send_beat(OP_STOP, 32'd355166);
    send_beat(OP_NOTE_OFF_LOW, 32'hFFFF_FFFF);
    send_beat(OP_DATA_TOP, 32'h0000_0000);
    send_beat(OP_TICK_UNDEF, 32'h5555_5555);
    send_beat(OP_CONTINUE, 32'hAAAA_AAAA);
    send_beat(OP_ACTIVE_SENSE, 32'd0);
    send_beat(OP_SYS_RESET, 32'd0);
    send_beat(OP_CLOCK, 32'hFFFF_FFF0);        // huge delta: stalled
    send_beat(OP_CLOCK, 32'h0000_0010);        // delta across the wrap
    send_beat(OP_CLOCK, 32'h0000_000F);        // delta of all ones: stalled
    send_beat(OP_START, 32'h0000_000F);        // window survives a restart
    send_beat(OP_CLOCK, 32'h0000_5150);
    send_beat(OP_CLOCK, 32'h0000_A291);
    send_beat(OP_CLOCK, 32'h0000_F3D2);
    send_beat(OP_STOP, 32'h0000_F3D2);
  endtask

  task run_phase(input int target);
    int          goal;
    int          n_clk;
    logic [OP_W-1:0] b;
    goal  = sent_events + target;
    stamp = $urandom;
    while (sent_events < goal) begin
      if ($urandom_range(99) < 80) begin
        if ($urandom_range(99) < 10) stamp = 32'hFFFF_FFFF - $urandom_range(2000000, 0);
        send_beat(OP_START, stamp);
        n_clk = $urandom_range(40, 1);
        repeat (n_clk) begin
          if ($urandom_range(99) < 5) send_beat(8'($urandom_range(255)), $urandom);
          stamp = stamp + next_delta();
          send_beat(OP_CLOCK, stamp);
        end
        if ($urandom_range(99) < 85) send_beat(OP_STOP, stamp);
      end else begin
        b = 8'($urandom_range(255));
        send_beat(b, ($urandom_range(1) == 1) ? stamp : 32'($urandom));
      end
    end
  endtask

  initial begin
    logic [THR_W-1:0] limits [6];
    int               modes_in [4];
    int               modes_out [4];
    sb = new();
    limits    = '{24'hFF_FFFF, 24'd0, 24'd500000, 24'($urandom), 24'd240, THRESH_RESET};
    modes_in  = '{0, 78, 0, 23};
    modes_out = '{0, 0, 78, 23};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain();
    for (int p = 0; p < 6; p++) begin
      idle_pct  = modes_in[p % 4];
      stall_pct = modes_out[p % 4];
      write_threshold(limits[p]);
      run_phase(PHASE_EVENTS);
      drain();
    end

    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
